>>> rtl/swsnd_pkg.sv
// Package for the sliding-window sender: sizes, command, packet-kind and
// configuration register codes shared by the RTL and the port checker.
// No dependencies.
package swsnd_pkg;

    localparam int WINDOW       = 4;
    localparam int SEQ_SPACE    = 8;
    localparam int PAYLOAD_BITS = 64;

    localparam int SEQ_W   = 3;
    localparam int SLOT_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int OUT_W   = $clog2(WINDOW + 1);
    // Working width for small sums and compares of sequence and slot values.
    localparam int CMP_W   = 10;

    localparam int TIMER_W = 16;
    localparam int DUP_W   = 4;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [1:0] CMD_SEND = 2'd0;
    localparam logic [1:0] CMD_ACK  = 2'd1;
    localparam logic [1:0] CMD_TICK = 2'd2;

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_NEW  = 2'd1;
    localparam logic [1:0] KIND_RETX = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DUP_ACK_THR   = 1'd1;

    localparam logic [TIMER_W-1:0] TIMEOUT_RESET = 16'd20;
    localparam logic [DUP_W-1:0]   DUP_THR_RESET = 4'd3;

endpackage

>>> rtl/sliding_window_sender.sv
// Sliding-window reliable-transfer sender with cumulative acks, fast
// retransmit on repeated base acks and a single retransmit timer.
// Each status result is registered in the single result register between the
// channels; throughput one item per cycle while the result channel takes results.
// Reset (aresetn low, synchronous) empties the window, disarms the timer and
// restores timeout_ticks = 20 and dup_ack_threshold = 3.
module sliding_window_sender (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // configuration write port
    input  logic                                 cfg_wr_en,
    input  logic [swsnd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [swsnd_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    // input channel
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [1:0]                           s_command,
    input  logic [63:0]                          s_payload,
    input  logic [2:0]                           s_ack_number,
    input  logic                                 s_ack_checksum_ok,
    // result channel
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [1:0]                           m_packet_kind,
    output logic [2:0]                           m_packet_seqnum,
    output logic [63:0]                          m_packet_payload,
    output logic                                 m_accepted,
    output logic                                 m_window_full,
    output logic                                 m_timer_running
);
    import swsnd_pkg::*;

    // configuration
    logic [TIMER_W-1:0] timeout_reg;
    logic [DUP_W-1:0]   dup_thr_reg;

    // sender state
    logic [63:0]        window_store [WINDOW];
    logic [SEQ_W-1:0]   base_seq_reg,    base_seq_next;
    logic [SEQ_W-1:0]   next_seq_reg,    next_seq_next;
    logic [OUT_W-1:0]   outstanding_reg, outstanding_next;
    logic [DUP_W-1:0]   dup_count_reg,   dup_count_next;
    logic [TIMER_W-1:0] timer_left_reg,  timer_left_next;
    logic               timer_armed_reg, timer_armed_next;
    logic [SLOT_W-1:0]  ring_head_reg,   ring_head_next;

    // result register
    logic               m_valid_reg;
    logic [1:0]         kind_reg,  kind_next;
    logic [2:0]         seq_reg,   seq_next;
    logic [63:0]        pay_reg,   pay_next;
    logic               acc_reg,   acc_next;
    logic               full_reg;
    logic               timer_run_reg;

    logic               in_xfer;
    logic               store_we;
    logic [SLOT_W-1:0]  store_slot;
    logic [63:0]        send_data;
    logic [63:0]        base_data;

    logic [CMP_W-1:0]   slot_sum;
    logic [CMP_W-1:0]   head_sum;
    logic [CMP_W-1:0]   dist_raw;
    logic [CMP_W-1:0]   ack_dist;
    logic [CMP_W-1:0]   outst_ext;
    logic [DUP_W-1:0]   dup_inc;
    logic [CMP_W-1:0]   seq_inc;

    // Accept a new item whenever the result register is empty or drains now.
    assign s_ready = !m_valid_reg || m_ready;
    assign in_xfer = s_valid && s_ready;

    // Keep only the low PAYLOAD_BITS of the payload.
    assign send_data = s_payload & ({64{1'b1}} >> (64 - PAYLOAD_BITS));
    assign base_data = window_store[ring_head_reg];

    assign outst_ext = CMP_W'(outstanding_reg);
    // Slot of the new packet: head + outstanding, wrapped once.
    assign slot_sum  = CMP_W'(ring_head_reg) + outst_ext;
    // Ack distance from base, modulo the sequence space.
    assign dist_raw  = CMP_W'(s_ack_number) + CMP_W'(SEQ_SPACE) - CMP_W'(base_seq_reg);
    assign ack_dist  = (dist_raw >= CMP_W'(SEQ_SPACE)) ? dist_raw - CMP_W'(SEQ_SPACE)
                                                       : dist_raw;
    assign head_sum  = CMP_W'(ring_head_reg) + ack_dist;
    assign dup_inc   = dup_count_reg + 1'b1;
    assign seq_inc   = CMP_W'(next_seq_reg) + 1'b1;

    assign store_slot = (slot_sum >= CMP_W'(WINDOW)) ? SLOT_W'(slot_sum - CMP_W'(WINDOW))
                                                     : SLOT_W'(slot_sum);

    always_comb begin
        base_seq_next    = base_seq_reg;
        next_seq_next    = next_seq_reg;
        outstanding_next = outstanding_reg;
        dup_count_next   = dup_count_reg;
        timer_left_next  = timer_left_reg;
        timer_armed_next = timer_armed_reg;
        ring_head_next   = ring_head_reg;
        kind_next        = KIND_NONE;
        seq_next         = '0;
        pay_next         = '0;
        acc_next         = 1'b0;
        store_we         = 1'b0;

        unique case (s_command)
            CMD_SEND: begin
                if (outst_ext < CMP_W'(WINDOW)) begin
                    store_we         = 1'b1;
                    // arm the timer when the window was empty
                    if (outstanding_reg == '0) begin
                        timer_left_next  = timeout_reg;
                        timer_armed_next = 1'b1;
                    end
                    outstanding_next = outstanding_reg + 1'b1;
                    kind_next        = KIND_NEW;
                    seq_next         = next_seq_reg;
                    pay_next         = send_data;
                    acc_next         = 1'b1;
                    next_seq_next    = (seq_inc >= CMP_W'(SEQ_SPACE)) ? '0
                                                                      : SEQ_W'(seq_inc);
                end
            end
            CMD_ACK: begin
                if (s_ack_checksum_ok && (CMP_W'(s_ack_number) < CMP_W'(SEQ_SPACE))) begin
                    if ((ack_dist != '0) && (ack_dist <= outst_ext)) begin
                        // slide the base and free the covered slots
                        base_seq_next    = s_ack_number;
                        ring_head_next   = (head_sum >= CMP_W'(WINDOW))
                                         ? SLOT_W'(head_sum - CMP_W'(WINDOW))
                                         : SLOT_W'(head_sum);
                        outstanding_next = OUT_W'(outst_ext - ack_dist);
                        dup_count_next   = '0;
                        if (outst_ext == ack_dist) begin
                            timer_armed_next = 1'b0;
                            timer_left_next  = '0;
                        end else begin
                            timer_left_next  = timeout_reg;
                            timer_armed_next = 1'b1;
                        end
                    end else if ((ack_dist == '0) && (outstanding_reg != '0)) begin
                        dup_count_next = dup_inc;
                        if (dup_inc >= dup_thr_reg) begin
                            // fast retransmit of the base packet
                            kind_next        = KIND_RETX;
                            seq_next         = base_seq_reg;
                            pay_next         = base_data;
                            timer_left_next  = timeout_reg;
                            timer_armed_next = 1'b1;
                            dup_count_next   = '0;
                        end
                    end
                end
            end
            CMD_TICK: begin
                if (timer_armed_reg) begin
                    if (timer_left_reg <= TIMER_W'(1)) begin
                        if (outstanding_reg != '0) begin
                            // timeout: resend the base packet and reload
                            kind_next        = KIND_RETX;
                            seq_next         = base_seq_reg;
                            pay_next         = base_data;
                            timer_left_next  = timeout_reg;
                            timer_armed_next = 1'b1;
                        end else begin
                            timer_armed_next = 1'b0;
                            timer_left_next  = '0;
                        end
                    end else begin
                        timer_left_next = timer_left_reg - 1'b1;
                    end
                end
            end
            default: begin
                // unknown command: status result only
            end
        endcase
    end

    // Configuration registers; the user writes them only while the block is idle (not enforced here).
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= TIMEOUT_RESET;
            dup_thr_reg <= DUP_THR_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_TIMEOUT_TICKS: timeout_reg <= cfg_wdata[TIMER_W-1:0];
                REG_DUP_ACK_THR:   dup_thr_reg <= cfg_wdata[DUP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Window ring: write the sent payload into its slot, no reset needed.
    always_ff @(posedge aclk) begin
        if (in_xfer && store_we) begin
            window_store[store_slot] <= send_data;
        end
    end

    // Sender state advances on every input transfer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_seq_reg    <= '0;
            next_seq_reg    <= '0;
            outstanding_reg <= '0;
            dup_count_reg   <= '0;
            timer_left_reg  <= '0;
            timer_armed_reg <= 1'b0;
            ring_head_reg   <= '0;
        end else if (in_xfer) begin
            base_seq_reg    <= base_seq_next;
            next_seq_reg    <= next_seq_next;
            outstanding_reg <= outstanding_next;
            dup_count_reg   <= dup_count_next;
            timer_left_reg  <= timer_left_next;
            timer_armed_reg <= timer_armed_next;
            ring_head_reg   <= ring_head_next;
        end
    end

    // Result register: load on input transfer, drop valid once taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (in_xfer) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            kind_reg <= kind_next;
            seq_reg  <= seq_next;
            pay_reg  <= pay_next;
            acc_reg  <= acc_next;
            full_reg <= (CMP_W'(outstanding_next) == CMP_W'(WINDOW));
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_packet_kind    = kind_reg;
    assign m_packet_seqnum  = seq_reg;
    assign m_packet_payload = pay_reg;
    assign m_accepted       = acc_reg;
    assign m_window_full    = full_reg;
    // timer state after the step equals the live register while a result waits
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            timer_run_reg <= timer_armed_next;
        end
    end
    assign m_timer_running  = timer_run_reg;

endmodule

>>> rtl/swsnd_checker.sv
// Port-level checker for the sliding-window sender, bound to the top level.
// Depends on swsnd_pkg for packet-kind and command codes.
module swsnd_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic [1:0]                    s_command,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [1:0]                    m_packet_kind,
    input logic [2:0]                    m_packet_seqnum,
    input logic [63:0]                   m_packet_payload,
    input logic                          m_accepted,
    input logic                          m_timer_running
);
    import swsnd_pkg::*;

    // A result that is not taken stays.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result dropped before transfer");

    // No packet means zero sequence number and payload.
    a_none_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_packet_kind == KIND_NONE) |->
            (m_packet_seqnum == 3'd0) && (m_packet_payload == 64'd0))
        else $error("idle result carries packet fields");

    // An accepted send always emits a new packet.
    a_acc_new: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_accepted |-> (m_packet_kind == KIND_NEW))
        else $error("accepted send without new packet");

    // Any packet leaves the retransmit timer armed.
    a_pkt_timer: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_packet_kind != KIND_NONE) |-> m_timer_running)
        else $error("packet sent with timer stopped");

    // Only a send can produce a new packet.
    a_new_from_send: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_command != CMD_SEND) |=>
            m_valid && (m_packet_kind != KIND_NEW))
        else $error("new packet from a non-send item");

endmodule

bind sliding_window_sender swsnd_checker u_swsnd_checker (.*);

>>> test/tb_sliding_window_sender.sv
// Self-checking testbench for sliding_window_sender: a directed script, then random
// send/ack/tick traffic under several register settings, checked against an in-bench predictor.
// Depends on rtl/swsnd_pkg.sv and rtl/sliding_window_sender.sv.
module tb_sliding_window_sender;
    import swsnd_pkg::*;

    // command code 3 has no meaning in the block; it must leave the state alone
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam int RESET_CYCLES    = 11;
    localparam int PHASES          = 6;
    localparam int ITEMS_PER_PHASE = 300;
    localparam int SETTLE_CYCLES   = 4;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int OWED_DEPTH      = 8;

    typedef struct packed {
        logic [1:0]              kind;
        logic [SEQ_W-1:0]        seqnum;
        logic [63:0]             payload;
        logic                    accepted;
        logic                    window_full;
        logic                    timer_running;
    } status_t;

    // One line of the directed script: either a register write or one input transfer.
    // Rows with typed set carry their expected status; the others use the predictor.
    typedef struct packed {
        bit                      is_write;
        logic [CFG_IDX_W-1:0]    reg_idx;
        logic [CFG_DATA_W-1:0]   reg_val;
        logic [1:0]              cmd;
        logic [63:0]             data;
        logic [SEQ_W-1:0]        ack;
        logic                    ack_ok;
        bit                      typed;
        status_t                 want;
    } script_row_t;

    logic                    aclk = 1'b0;
    logic                    aresetn = 1'b0;
    logic                    cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]    cfg_index = '0;
    logic [CFG_DATA_W-1:0]   cfg_wdata = '0;
    logic                    s_valid = 1'b0;
    logic                    s_ready;
    logic [1:0]              s_command = CMD_SEND;
    logic [63:0]             s_payload = '0;
    logic [SEQ_W-1:0]        s_ack_number = '0;
    logic                    s_ack_checksum_ok = 1'b0;
    logic                    m_valid;
    logic                    m_ready = 1'b1;
    logic [1:0]              m_packet_kind;
    logic [SEQ_W-1:0]        m_packet_seqnum;
    logic [63:0]             m_packet_payload;
    logic                    m_accepted;
    logic                    m_window_full;
    logic                    m_timer_running;

    sliding_window_sender uut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_wr_en         (cfg_wr_en),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_command         (s_command),
        .s_payload         (s_payload),
        .s_ack_number      (s_ack_number),
        .s_ack_checksum_ok (s_ack_checksum_ok),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_packet_kind     (m_packet_kind),
        .m_packet_seqnum   (m_packet_seqnum),
        .m_packet_payload  (m_packet_payload),
        .m_accepted        (m_accepted),
        .m_window_full     (m_window_full),
        .m_timer_running   (m_timer_running)
    );

    always #1 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Sender predictor: its own copy of the window ring, sequence state,
    // duplicate-ack counter, retransmit timer and both registers.
    // ------------------------------------------------------------------
    logic [63:0]             window_slots [WINDOW];
    int unsigned             head_slot;
    int unsigned             in_flight;
    int unsigned             base_sn;
    int unsigned             next_sn;
    int unsigned             dup_acks;
    int unsigned             ticks_left;
    bit                      timer_on;
    logic [TIMER_W-1:0]      cfg_timeout;
    logic [DUP_W-1:0]        cfg_dup_thr;

    // status results still owed by the block, oldest first, in a small ring
    status_t                 owed_status [OWED_DEPTH];
    int unsigned             owed_wr = 0;
    int unsigned             owed_rd = 0;
    int unsigned             error_count = 0;
    int unsigned             cycle_count = 0;

    function automatic void arm_timer();
        ticks_left = 32'(cfg_timeout);
        timer_on   = 1'b1;
    endfunction

    // Advance the predictor by one transfer and return the status it yields.
    function automatic status_t next_status(input logic [1:0] cmd, input logic [63:0] data,
                                            input logic [SEQ_W-1:0] ack, input logic ack_ok);
        status_t     st;
        int unsigned ack_dist;
        st = '0;
        case (cmd)
            CMD_SEND: begin
                // refuse when every slot is outstanding
                if (in_flight < WINDOW) begin
                    window_slots[SLOT_W'((head_slot + in_flight) % WINDOW)] = data;
                    if (in_flight == 0)
                        arm_timer();
                    in_flight++;
                    st.kind     = KIND_NEW;
                    st.seqnum   = SEQ_W'(next_sn);
                    st.payload  = data;
                    st.accepted = 1'b1;
                    next_sn     = (next_sn + 1) % SEQ_SPACE;
                end
            end
            CMD_ACK: begin
                if (ack_ok && ack < SEQ_SPACE) begin
                    ack_dist = (ack + SEQ_SPACE - base_sn) % SEQ_SPACE;
                    if (ack_dist != 0 && ack_dist <= in_flight) begin
                        // cumulative ack slides the base
                        base_sn   = 32'(ack);
                        head_slot = (head_slot + ack_dist) % WINDOW;
                        in_flight = in_flight - ack_dist;
                        dup_acks  = 0;
                        if (in_flight == 0) begin
                            timer_on   = 1'b0;
                            ticks_left = 0;
                        end else begin
                            arm_timer();
                        end
                    end else if (ack_dist == 0 && in_flight > 0) begin
                        dup_acks = (dup_acks + 1) & 4'hF;
                        if (dup_acks >= cfg_dup_thr) begin
                            st.kind    = KIND_RETX;
                            st.seqnum  = SEQ_W'(base_sn);
                            st.payload = window_slots[SLOT_W'(head_slot)];
                            arm_timer();
                            dup_acks   = 0;
                        end
                    end
                end
            end
            CMD_TICK: begin
                if (timer_on) begin
                    if (ticks_left <= 1) begin
                        if (in_flight > 0) begin
                            st.kind    = KIND_RETX;
                            st.seqnum  = SEQ_W'(base_sn);
                            st.payload = window_slots[SLOT_W'(head_slot)];
                            arm_timer();
                        end else begin
                            timer_on   = 1'b0;
                            ticks_left = 0;
                        end
                    end else begin
                        ticks_left--;
                    end
                end
            end
            default: ;
        endcase
        st.window_full   = (in_flight == WINDOW);
        st.timer_running = timer_on;
        return st;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        error_count++;
        $display("%0t: mismatch on %s: got %h, want %h", $time, what, got, want);
    endtask

    // ------------------------------------------------------------------
    // Input channel driver. Drive at the falling edge, hold until the
    // transfer, then advance the predictor and queue the expectation.
    // ------------------------------------------------------------------
    task automatic send_transfer(input logic [1:0] cmd, input logic [63:0] data,
                                 input logic [SEQ_W-1:0] ack, input logic ack_ok,
                                 input bit typed, input status_t want);
        status_t predicted;
        @(negedge aclk);
        s_valid           <= 1'b1;
        s_command         <= cmd;
        s_payload         <= data;
        s_ack_number      <= ack;
        s_ack_checksum_ok <= ack_ok;
        do @(posedge aclk); while (!s_ready);
        predicted = next_status(cmd, data, ack, ack_ok);
        owed_status[owed_wr % OWED_DEPTH] = typed ? want : predicted;
        owed_wr++;
    endtask

    // Write one register with the block idle: drop valid, wait for every
    // owed status, let the block settle, then pulse the write enable.
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        s_valid <= 1'b0;
        while (owed_wr != owed_rd) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        if (idx == REG_TIMEOUT_TICKS)
            cfg_timeout = val[TIMER_W-1:0];
        else
            cfg_dup_thr = val[DUP_W-1:0];
    endtask

    function automatic script_row_t item_row(input logic [1:0] cmd, input logic [63:0] data,
                                             input logic [SEQ_W-1:0] ack, input logic ack_ok);
        script_row_t r;
        r = '0;
        r.cmd    = cmd;
        r.data   = data;
        r.ack    = ack;
        r.ack_ok = ack_ok;
        return r;
    endfunction

    function automatic script_row_t checked_row(input logic [1:0] cmd, input logic [63:0] data,
                                                input logic [SEQ_W-1:0] ack, input logic ack_ok,
                                                input status_t want);
        script_row_t r;
        r       = item_row(cmd, data, ack, ack_ok);
        r.typed = 1'b1;
        r.want  = want;
        return r;
    endfunction

    function automatic script_row_t write_row(input logic [CFG_IDX_W-1:0] idx,
                                              input logic [CFG_DATA_W-1:0] val);
        script_row_t r;
        r = '0;
        r.is_write = 1'b1;
        r.reg_idx  = idx;
        r.reg_val  = val;
        return r;
    endfunction

    script_row_t script [25];

    // ------------------------------------------------------------------
    // Result channel: the receiver stalls on a pattern of its own that
    // changes mode at random, always-ready stretches included.
    // ------------------------------------------------------------------
    int unsigned rx_mode = 0;
    int unsigned rx_left = 0;

    always @(negedge aclk) begin
        if (rx_left == 0) begin
            rx_mode <= $urandom_range(0, 3);
            rx_left <= $urandom_range(16, 96);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            0: begin
                m_ready <= 1'b1;
            end
            1: begin
                m_ready <= ($urandom_range(0, 9) < 7);
            end
            2: begin
                m_ready <= (rx_left % 5 != 0);
            end
            default: begin
                m_ready <= ((rx_left & 15) >= 6);
            end
        endcase
    end

    // Compare every status transfer, field by field, with the oldest expectation.
    always @(posedge aclk) begin : check_status
        status_t want;
        if (aresetn && m_valid && m_ready) begin
            if (owed_wr == owed_rd) begin
                report_mismatch("unexpected status", m_packet_payload, '0);
            end else begin
                want = owed_status[owed_rd % OWED_DEPTH];
                owed_rd++;
                if (m_packet_kind !== want.kind)
                    report_mismatch("packet_kind", 64'(m_packet_kind), 64'(want.kind));
                if (m_packet_seqnum !== want.seqnum)
                    report_mismatch("packet_seqnum", 64'(m_packet_seqnum), 64'(want.seqnum));
                if (m_packet_payload !== want.payload)
                    report_mismatch("packet_payload", m_packet_payload, want.payload);
                if (m_accepted !== want.accepted)
                    report_mismatch("accepted", 64'(m_accepted), 64'(want.accepted));
                if (m_window_full !== want.window_full)
                    report_mismatch("window_full", 64'(m_window_full), 64'(want.window_full));
                if (m_timer_running !== want.timer_running)
                    report_mismatch("timer_running", 64'(m_timer_running),
                                    64'(want.timer_running));
            end
        end
    end

    // Watchdog: a hung handshake ends the run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        int unsigned      pick;
        int unsigned      burst_left;
        int unsigned      gap;
        int unsigned      tmo;
        int unsigned      thr;
        logic [1:0]       cmd;
        logic [63:0]      data;
        logic [SEQ_W-1:0] ack;
        logic             ack_ok;

        // predictor starts from the reset state of the block
        foreach (window_slots[i])
            window_slots[i] = '0;
        head_slot   = 0;
        in_flight   = 0;
        base_sn     = 0;
        next_sn     = 0;
        dup_acks    = 0;
        ticks_left  = 0;
        timer_on    = 1'b0;
        cfg_timeout = TIMEOUT_RESET;
        cfg_dup_thr = DUP_THR_RESET;

        // Directed script, starting from reset values (timeout 20, threshold 3).
        // tick with the timer disarmed, ack into an empty window, unused command
        script[0]  = checked_row(CMD_TICK, 64'd0, 3'd0, 1'b0, '0);
        script[1]  = checked_row(CMD_ACK, 64'd0, 3'd0, 1'b1, '0);
        script[2]  = checked_row(CMD_UNUSED, '1, 3'd7, 1'b1, '0);
        // fill the window: the first send arms the timer
        script[3]  = checked_row(CMD_SEND, '1, 3'd0, 1'b0,
                                 '{KIND_NEW, 3'd0, {64{1'b1}}, 1'b1, 1'b0, 1'b1});
        script[4]  = checked_row(CMD_SEND, 64'd0, 3'd0, 1'b0,
                                 '{KIND_NEW, 3'd1, 64'd0, 1'b1, 1'b0, 1'b1});
        script[5]  = item_row(CMD_SEND, 64'hA5A5_A5A5_A5A5_A5A5, 3'd0, 1'b0);
        script[6]  = item_row(CMD_SEND, 64'h8000_0000_0000_0001, 3'd0, 1'b0);
        // send into a full window is refused
        script[7]  = checked_row(CMD_SEND, 64'h5A5A_5A5A_5A5A_5A5A, 3'd0, 1'b0,
                                 '{KIND_NONE, 3'd0, 64'd0, 1'b0, 1'b1, 1'b1});
        // bad checksum, ack beyond the sent data
        script[8]  = item_row(CMD_ACK, 64'd0, 3'd2, 1'b0);
        script[9]  = item_row(CMD_ACK, 64'd0, 3'd5, 1'b1);
        // three duplicate base acks reach the threshold
        script[10] = item_row(CMD_ACK, 64'd0, 3'd0, 1'b1);
        script[11] = item_row(CMD_ACK, 64'd0, 3'd0, 1'b1);
        script[12] = item_row(CMD_ACK, 64'd0, 3'd0, 1'b1);
        script[13] = item_row(CMD_ACK, 64'd0, 3'd2, 1'b1);
        // zero timeout and zero threshold: every duplicate resends, next tick expires
        script[14] = write_row(REG_TIMEOUT_TICKS, 16'd0);
        script[15] = write_row(REG_DUP_ACK_THR, 16'd0);
        script[16] = item_row(CMD_ACK, 64'd0, 3'd2, 1'b1);
        script[17] = item_row(CMD_TICK, 64'd0, 3'd0, 1'b0);
        // ack everything: window empties, timer stops
        script[18] = checked_row(CMD_ACK, 64'd0, 3'd4, 1'b1, '0);
        script[19] = checked_row(CMD_TICK, 64'd0, 3'd0, 1'b0, '0);
        // largest timeout and threshold; upper data bits of the threshold are dropped
        script[20] = write_row(REG_TIMEOUT_TICKS, 16'hFFFF);
        script[21] = write_row(REG_DUP_ACK_THR, 16'hFFFF);
        script[22] = item_row(CMD_SEND, 64'h0123_4567_89AB_CDEF, 3'd0, 1'b0);
        script[23] = item_row(CMD_TICK, 64'd0, 3'd0, 1'b0);
        script[24] = item_row(CMD_ACK, 64'd0, 3'd5, 1'b1);

        // hold reset, release at a falling edge
        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (script[i]) begin
            if (script[i].is_write)
                write_register(script[i].reg_idx, script[i].reg_val);
            else
                send_transfer(script[i].cmd, script[i].data, script[i].ack, script[i].ack_ok,
                              script[i].typed, script[i].want);
        end

        // Random traffic, one register setting per phase, extremes first.
        burst_left = 0;
        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: begin
                    tmo = 0;
                    thr = 0;
                end
                1: begin
                    tmo = 16'hFFFF;
                    thr = 15;
                end
                2: begin
                    tmo = 1;
                    thr = 1;
                end
                default: begin
                    tmo = $urandom_range(2, 12);
                    thr = $urandom_range(0, 6);
                end
            endcase
            write_register(REG_TIMEOUT_TICKS, CFG_DATA_W'(tmo));
            // random upper bits must not leak into the 4-bit threshold
            write_register(REG_DUP_ACK_THR, {12'($urandom), 4'(thr)});

            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // sender bursts: drop valid for a random gap between bursts,
                // now and then run a long burst with no gap at all
                if (burst_left == 0) begin
                    gap        = $urandom_range(0, 6);
                    burst_left = ($urandom_range(0, 7) == 0) ? 120 : $urandom_range(1, 30);
                    repeat (gap) begin
                        @(negedge aclk);
                        s_valid <= 1'b0;
                    end
                end
                burst_left--;

                pick = $urandom_range(0, 9);
                if (pick == 0)
                    data = '1;
                else if (pick == 1)
                    data = '0;
                else
                    data = {$urandom, $urandom};
                ack_ok = ($urandom_range(0, 9) != 0);
                ack    = SEQ_W'($urandom);

                pick = $urandom_range(0, 99);
                if (pick < 40) begin
                    cmd = CMD_SEND;
                end else if (pick < 75) begin
                    cmd  = CMD_ACK;
                    // mostly well-formed acks: slide inside the sent data or repeat the base
                    pick = $urandom_range(0, 99);
                    if (in_flight > 0 && pick < 40)
                        ack = SEQ_W'((base_sn + $urandom_range(1, in_flight)) % SEQ_SPACE);
                    else if (pick < 85)
                        ack = SEQ_W'(base_sn);
                end else if (pick < 98) begin
                    cmd = CMD_TICK;
                end else begin
                    cmd = CMD_UNUSED;
                end
                send_transfer(cmd, data, ack, ack_ok, 1'b0, '0);
            end
        end

        // drain: wait for every owed status, then let the block settle
        @(negedge aclk);
        s_valid <= 1'b0;
        while (owed_wr != owed_rd) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
